FILE: rtl/e2c_pkg.sv
package e2c_pkg;

  localparam int unsigned PIPE_DEPTH = 8;

  localparam logic [31:0] LAST_SECOND   = 32'd4102444799;
  localparam logic [15:0] DAY_RECIP     = 16'd49710;
  localparam logic [9:0]  DAY_ODD       = 10'd675;
  localparam logic [5:0]  QUAD_RECIP    = 6'd44;
  localparam logic [10:0] QUAD_DAYS     = 11'd1461;
  localparam logic [14:0] WEEK_RECIP    = 15'd18724;
  localparam logic [2:0]  WEEK_DAYS     = 3'd7;
  localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;
  localparam logic [5:0]  HOUR_RECIP    = 6'd36;
  localparam logic [11:0] HOUR_SECONDS  = 12'd3600;
  localparam logic [11:0] MIN_RECIP     = 12'd2184;
  localparam logic [5:0]  MIN_SECONDS   = 6'd60;
  localparam logic [7:0]  YEAR_BASE     = 8'd70;
  localparam logic [10:0] YEAR_DAYS     = 11'd365;
  localparam logic [10:0] TWO_YEAR_DAYS = 11'd730;
  localparam logic [10:0] LEAP_END_DAYS = 11'd1096;

  localparam logic [8:0] MONTH_START_COMMON [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };
  localparam logic [8:0] MONTH_START_LEAP [12] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

  typedef struct packed {
    logic [15:0] days;
    logic [16:0] tod;
  } split_t;

  typedef struct packed {
    logic [5:0]  quad;
    logic [10:0] quad_rem;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [10:0] tot_min;
    logic [5:0]  sec;
  } fields_t;

  typedef struct packed {
    logic [7:0] years_since_1900;
    logic [8:0] day_of_year;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic [2:0] weekday;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
  } cal_t;

endpackage

FILE: rtl/e2c_split.sv
module e2c_split import e2c_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] secs_i,
  output split_t      split_o
);

  logic [31:0] sat;
  logic [40:0] p1_d, p1_q;
  logic [24:0] x1_q;
  logic [6:0]  lo1_q;

  logic [15:0] q2_d, q2_q;
  logic [25:0] prod2;
  logic [10:0] r2_d, r2_q;
  logic [6:0]  lo2_q;

  logic [10:0] rd;
  split_t      split_d, split_q;

  // 86400 = 128 * 675
  assign sat  = (secs_i > LAST_SECOND) ? LAST_SECOND : secs_i;
  assign p1_d = 41'(sat[31:7]) * 41'(DAY_RECIP);

  assign q2_d  = p1_q[40:25];
  assign prod2 = 26'(q2_d) * 26'(DAY_ODD);
  assign r2_d  = 11'(26'(x1_q) - prod2);

  always_comb begin
    if (r2_q >= 11'(DAY_ODD)) begin
      split_d.days = q2_q + 16'd1;
      rd           = r2_q - 11'(DAY_ODD);
    end else begin
      split_d.days = q2_q;
      rd           = r2_q;
    end
    split_d.tod = {rd[9:0], lo2_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q    <= p1_d;
      x1_q    <= sat[31:7];
      lo1_q   <= sat[6:0];
      q2_q    <= q2_d;
      r2_q    <= r2_d;
      lo2_q   <= lo1_q;
      split_q <= split_d;
    end
  end

  assign split_o = split_q;

endmodule

FILE: rtl/e2c_fields.sv
module e2c_fields import e2c_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  split_t  split_i,
  output fields_t fields_o
);

  logic [16:0] w4_d, w4_q;
  logic [15:0] d4_q;
  logic [16:0] tod4_q;
  logic [21:0] pq_d, pq_q;
  logic [31:0] pw_d, pw_q;
  logic [22:0] ph_d, ph_q;
  logic [28:0] pm_d, pm_q;

  logic [5:0]  qq5_d, qq5_q;
  logic [14:0] qw5;
  logic [5:0]  qh5_d, qh5_q;
  logic [11:0] qm5_d, qm5_q;
  logic [11:0] rq5_d, rq5_q;
  logic [3:0]  rw5_d, rw5_q;
  logic [12:0] rh5_d, rh5_q;
  logic [6:0]  rm5_d, rm5_q;

  fields_t     fields_d, fields_q;

  assign w4_d = 17'(split_i.days) + 17'(EPOCH_WEEKDAY);
  assign pq_d = 22'(split_i.days) * 22'(QUAD_RECIP);
  assign pw_d = 32'(w4_d) * 32'(WEEK_RECIP);
  assign ph_d = 23'(split_i.tod) * 23'(HOUR_RECIP);
  assign pm_d = 29'(split_i.tod) * 29'(MIN_RECIP);

  // estimates are exact or one low
  assign qq5_d = pq_q[21:16];
  assign qw5   = pw_q[31:17];
  assign qh5_d = ph_q[22:17];
  assign qm5_d = pm_q[28:17];
  assign rq5_d = 12'(d4_q - 16'(qq5_d) * 16'(QUAD_DAYS));
  assign rw5_d = 4'(w4_q - 17'(qw5) * 17'(WEEK_DAYS));
  assign rh5_d = 13'(tod4_q - 17'(qh5_d) * 17'(HOUR_SECONDS));
  assign rm5_d = 7'(tod4_q - 17'(qm5_d) * 17'(MIN_SECONDS));

  always_comb begin
    if (rq5_q >= 12'(QUAD_DAYS)) begin
      fields_d.quad     = qq5_q + 6'd1;
      fields_d.quad_rem = 11'(rq5_q - 12'(QUAD_DAYS));
    end else begin
      fields_d.quad     = qq5_q;
      fields_d.quad_rem = 11'(rq5_q);
    end
    fields_d.weekday = (rw5_q >= 4'(WEEK_DAYS)) ? 3'(rw5_q - 4'(WEEK_DAYS)) : 3'(rw5_q);
    fields_d.hour    = (rh5_q >= 13'(HOUR_SECONDS)) ? 5'(qh5_q + 6'd1) : 5'(qh5_q);
    if (rm5_q >= 7'(MIN_SECONDS)) begin
      fields_d.tot_min = 11'(qm5_q + 12'd1);
      fields_d.sec     = 6'(rm5_q - 7'(MIN_SECONDS));
    end else begin
      fields_d.tot_min = 11'(qm5_q);
      fields_d.sec     = 6'(rm5_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w4_q     <= w4_d;
      d4_q     <= split_i.days;
      tod4_q   <= split_i.tod;
      pq_q     <= pq_d;
      pw_q     <= pw_d;
      ph_q     <= ph_d;
      pm_q     <= pm_d;
      qq5_q    <= qq5_d;
      qh5_q    <= qh5_d;
      qm5_q    <= qm5_d;
      rq5_q    <= rq5_d;
      rw5_q    <= rw5_d;
      rh5_q    <= rh5_d;
      rm5_q    <= rm5_d;
      fields_q <= fields_d;
    end
  end

  assign fields_o = fields_q;

endmodule

FILE: rtl/e2c_cal.sv
module e2c_cal import e2c_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  fields_t fields_i,
  output cal_t    cal_o
);

  logic [7:0] year7_d, year7_q;
  logic [8:0] yday7_d, yday7_q;
  logic       leap7_d, leap7_q;
  logic [1:0] yi;
  logic [5:0] min7_d, min7_q;
  logic [2:0] wd7_q;
  logic [4:0] hour7_q;
  logic [5:0] sec7_q;

  logic [3:0] mon;
  logic [8:0] mstart;
  cal_t       cal_d, cal_q;

  always_comb begin
    yday7_d = 9'(fields_i.quad_rem);
    leap7_d = 1'b0;
    yi      = 2'd0;
    if (fields_i.quad_rem >= LEAP_END_DAYS) begin
      yi      = 2'd3;
      yday7_d = 9'(fields_i.quad_rem - LEAP_END_DAYS);
    end else if (fields_i.quad_rem >= TWO_YEAR_DAYS) begin
      yi      = 2'd2;
      leap7_d = 1'b1;
      yday7_d = 9'(fields_i.quad_rem - TWO_YEAR_DAYS);
    end else if (fields_i.quad_rem >= YEAR_DAYS) begin
      yi      = 2'd1;
      yday7_d = 9'(fields_i.quad_rem - YEAR_DAYS);
    end
  end

  assign year7_d = YEAR_BASE + {fields_i.quad, 2'b00} + 8'(yi);
  assign min7_d  = 6'(fields_i.tot_min - 11'(fields_i.hour) * 11'(MIN_SECONDS));

  always_comb begin
    mon = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if ((leap7_q ? MONTH_START_LEAP[m] : MONTH_START_COMMON[m]) <= yday7_q) begin
        mon = mon + 4'd1;
      end
    end
    mstart = leap7_q ? MONTH_START_LEAP[mon] : MONTH_START_COMMON[mon];
    cal_d.years_since_1900 = year7_q;
    cal_d.day_of_year      = yday7_q;
    cal_d.month_index      = mon;
    cal_d.day_of_month     = 5'(yday7_q - mstart + 9'd1);
    cal_d.weekday          = wd7_q;
    cal_d.hour_of_day      = hour7_q;
    cal_d.minute_of_hour   = min7_q;
    cal_d.second_of_minute = sec7_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      year7_q <= year7_d;
      yday7_q <= yday7_d;
      leap7_q <= leap7_d;
      min7_q  <= min7_d;
      wd7_q   <= fields_i.weekday;
      hour7_q <= fields_i.hour;
      sec7_q  <= fields_i.sec;
      cal_q   <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule

FILE: rtl/epoch_seconds_to_utc_calendar.sv
// channel   dir  width  contents (lsb first)
// s_axis    in   32     epoch_seconds
// m_axis    out  48     years_since_1900, day_of_year, month_index, day_of_month,
//                       weekday, hour_of_day, minute_of_hour, second_of_minute
//
// Eight-stage pipeline, one item per cycle while m_axis does not stall.
// The split into days and seconds of day and the later divides are
// reciprocal multiplies with one correction step each.
// Reset clears only the stage valid bits.
// A stall on m_axis holds every stage; s_axis_tready follows it.
module epoch_seconds_to_utc_calendar import e2c_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // epoch_seconds[31:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // years_since_1900[7:0], day_of_year[16:8], month_index[20:17], day_of_month[25:21],
  // weekday[28:26], hour_of_day[33:29], minute_of_hour[39:34],
  // second_of_minute[45:40], zero[47:46]
  output logic [47:0] m_axis_tdata_o
);

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_d, vld_q;
  split_t                split;
  fields_t               fields;
  cal_t                  cal;

  assign en = !vld_q[PIPE_DEPTH-1] || m_axis_tready_i;

  assign vld_d = en ? {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid_i} : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  e2c_split u_split (
    .clk_i   (clk_i),
    .en_i    (en),
    .secs_i  (s_axis_tdata_i),
    .split_o (split)
  );

  e2c_fields u_fields (
    .clk_i    (clk_i),
    .en_i     (en),
    .split_i  (split),
    .fields_o (fields)
  );

  e2c_cal u_cal (
    .clk_i    (clk_i),
    .en_i     (en),
    .fields_i (fields),
    .cal_o    (cal)
  );

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[PIPE_DEPTH-1];
  assign m_axis_tdata_o  = {2'b00, cal.second_of_minute, cal.minute_of_hour,
                            cal.hour_of_day, cal.weekday, cal.day_of_month,
                            cal.month_index, cal.day_of_year, cal.years_since_1900};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> vld_q[0])
    else $error("accepted item lost at first stage");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (cal.month_index <= 4'd11 && cal.hour_of_day <= 5'd23 &&
                         cal.minute_of_hour <= 6'd59 && cal.second_of_minute <= 6'd59 &&
                         cal.weekday <= 3'd6 && cal.day_of_month != 5'd0))
    else $error("calendar field out of range");

endmodule

FILE: tb/epoch_seconds_to_utc_calendar_test.sv
module epoch_seconds_to_utc_calendar_test;
  timeunit 1ns;
  timeprecision 1ps;

  import e2c_pkg::*;

  localparam longint unsigned SECS_PER_DAY   = 86400;
  localparam int unsigned     DAYS_PER_QUAD  = 1461;
  localparam int unsigned     LAST_DAY_INDEX = 47481;
  localparam int unsigned     MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned     YEAR_OFFSET [4] = '{0, 365, 730, 1096};

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;

  cal_t        expected_cal [$];
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned beyond_range;
  int unsigned mismatches;
  int unsigned burst_left;
  logic [15:0] stall_mask;
  int unsigned stall_phase;
  cal_t        got_cal;
  cal_t        want_cal;

  epoch_seconds_to_utc_calendar DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Calendar fields of one timestamp, saturated at the end of 2099.
  function automatic cal_t convert_epoch(input logic [31:0] secs_in);
    longint unsigned secs;
    longint unsigned days;
    int unsigned     tod;
    int unsigned     day_in_quad;
    int unsigned     year;
    int unsigned     left;
    int unsigned     mon;
    int unsigned     mlen;
    bit              leap;
    cal_t            r;
    secs = secs_in;
    if (secs > LAST_SECOND) begin
      secs = LAST_SECOND;
    end
    days        = secs / SECS_PER_DAY;
    tod         = int'(secs % SECS_PER_DAY);
    year        = 70 + 4 * int'(days / DAYS_PER_QUAD);
    day_in_quad = int'(days % DAYS_PER_QUAD);
    leap        = 1'b0;
    // 1970-based quads: common, common, leap, common
    if (day_in_quad >= 365) begin
      year++;
      day_in_quad -= 365;
      if (day_in_quad >= 365) begin
        year++;
        day_in_quad -= 365;
        if (day_in_quad >= 366) begin
          year++;
          day_in_quad -= 366;
        end else begin
          leap = 1'b1;
        end
      end
    end
    left = day_in_quad;
    mon  = 0;
    mlen = MONTH_DAYS[0];
    while (left >= mlen) begin
      left -= mlen;
      mon++;
      mlen = MONTH_DAYS[mon] + ((leap && mon == 1) ? 1 : 0);
    end
    r.years_since_1900 = 8'(year);
    r.day_of_year      = 9'(day_in_quad);
    r.month_index      = 4'(mon);
    r.day_of_month     = 5'(left + 1);
    r.weekday          = 3'((days + 4) % 7);
    r.hour_of_day      = 5'(tod / 3600);
    r.minute_of_hour   = 6'((tod % 3600) / 60);
    r.second_of_minute = 6'(tod % 60);
    return r;
  endfunction

  function automatic string cal_str(input cal_t c);
    return $sformatf("yr%0d yday%0d mon%0d mday%0d wday%0d %0d:%0d:%0d",
                     c.years_since_1900, c.day_of_year, c.month_index, c.day_of_month,
                     c.weekday, c.hour_of_day, c.minute_of_hour, c.second_of_minute);
  endfunction

  task automatic send_seconds(input logic [31:0] secs);
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= secs;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_cal.push_back(convert_epoch(secs));
    if (secs > LAST_SECOND) begin
      beyond_range++;
    end
    items_sent++;
    burst_left--;
  endtask

  task automatic test_directed();
    logic [31:0] cases [25] = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd31535999, 32'd31536000, 32'd63071999, 32'd63072000,
      32'd68169600, 32'd68256000, 32'd94694399, 32'd94694400,
      32'd951782400, 32'd978307199, 32'd2147483647, 32'd2147483648,
      32'd4102444799, 32'd4102444800, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555
    };
    foreach (cases[i]) begin
      send_seconds(cases[i]);
    end
  endtask

  // Random days with the time of day at midnight, at the last second, or anywhere;
  // part of them land right around the start of a year.
  task automatic test_day_edges(input int unsigned count);
    int unsigned     day;
    int unsigned     tod;
    longint unsigned secs;
    repeat (count) begin
      if ($urandom_range(0, 2) == 0) begin
        day = $urandom_range(0, 32) * DAYS_PER_QUAD + YEAR_OFFSET[$urandom_range(0, 3)];
        day = day + $urandom_range(0, 2);
        day = (day == 0) ? 0 : day - 1;
        if (day > LAST_DAY_INDEX) begin
          day = LAST_DAY_INDEX;
        end
      end else begin
        day = $urandom_range(0, LAST_DAY_INDEX);
      end
      case ($urandom_range(0, 2))
        0:       tod = 0;
        1:       tod = 86399;
        default: tod = $urandom_range(0, 86399);
      endcase
      secs = longint'(day) * SECS_PER_DAY + tod;
      send_seconds(secs[31:0]);
    end
  endtask

  task automatic test_uniform(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) begin
        send_seconds($urandom);
      end else begin
        send_seconds($urandom_range(LAST_SECOND, 0));
      end
    end
  endtask

  task automatic test_beyond_range(input int unsigned count);
    repeat (count) begin
      send_seconds($urandom_range(32'hFFFF_FFFF, LAST_SECOND + 1));
    end
  endtask

  // Receiver stalls follow a 16-bit mask that is redrawn whenever stall_phase[5:0] is zero.
  always @(posedge clk_i) begin
    if (stall_phase[5:0] == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_mask = '1;
        1:       stall_mask = 16'($urandom);
        2:       stall_mask = 16'($urandom | $urandom);
        default: stall_mask = 16'($urandom & $urandom);
      endcase
    end
    m_axis_tready_i <= stall_mask[stall_phase[3:0]];
    stall_phase = stall_phase + 1;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      got_cal.years_since_1900 = m_axis_tdata_o[7:0];
      got_cal.day_of_year      = m_axis_tdata_o[16:8];
      got_cal.month_index      = m_axis_tdata_o[20:17];
      got_cal.day_of_month     = m_axis_tdata_o[25:21];
      got_cal.weekday          = m_axis_tdata_o[28:26];
      got_cal.hour_of_day      = m_axis_tdata_o[33:29];
      got_cal.minute_of_hour   = m_axis_tdata_o[39:34];
      got_cal.second_of_minute = m_axis_tdata_o[45:40];
      if (expected_cal.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result %s", $realtime, cal_str(got_cal));
        end
      end else begin
        want_cal = expected_cal.pop_front();
        if (got_cal != want_cal || m_axis_tdata_o[47:46] != 2'b00) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch, expected %s, got %s pad %b", $realtime,
                     cal_str(want_cal), cal_str(got_cal), m_axis_tdata_o[47:46]);
          end
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("Timeout after %0d items sent, %0d results", items_sent, results_seen);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    stall_phase = 0;
    stall_mask  = '1;
    burst_left  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_day_edges(420);
    test_uniform(430);
    test_beyond_range(75);

    s_axis_tvalid_i <= 1'b0;
    while (expected_cal.size() != 0) @(posedge clk_i);
    repeat (4 * PIPE_DEPTH) @(posedge clk_i);

    $display("Converted %0d timestamps (%0d past 2099), %0d results checked, %0d mismatches",
             items_sent, beyond_range, results_seen, mismatches);
    if (mismatches == 0 && expected_cal.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/e2c_pkg.sv
rtl/e2c_split.sv
rtl/e2c_fields.sv
rtl/e2c_cal.sv
rtl/epoch_seconds_to_utc_calendar.sv
tb/epoch_seconds_to_utc_calendar_test.sv
